[src/mrdt_pkg.sv]
`default_nettype none
package mrdt_pkg;

    localparam int NUM_MOTORS = 2;
    localparam int MOTOR_W    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam logic [MOTOR_W-1:0] LAST_MOTOR = MOTOR_W'(NUM_MOTORS - 1);

    localparam logic [7:0] PAUSE_TICKS_RESET = 8'd10;

    // register index, taken from paddr[2]
    localparam logic REG_PAUSE_TICKS = 1'b0;

    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef enum logic [1:0] {
        MODE_STOPPED = 2'd0,
        MODE_RUNNING = 2'd1,
        MODE_PAUSE   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_BACK = 2'd2
    } t_dir;

    typedef struct packed {
        t_mode      mode;
        t_dir       wanted_dir;
        t_dir       applied_dir;
        logic [7:0] wanted_duty;
        logic [7:0] pause_count;
        t_dir       out_dir;
        logic [7:0] out_duty;
    } t_motor_state;

    typedef struct packed {
        logic               rd_en;
        logic [MOTOR_W-1:0] rd_addr;
        logic               wr_en;
        logic [MOTOR_W-1:0] wr_addr;
        t_motor_state       wr_data;
    } t_mem_req;

endpackage
`default_nettype wire

[src/mrdt_state_mem.sv]
`default_nettype none
module mrdt_state_mem (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mrdt_pkg::t_mem_req    i_req,
    output mrdt_pkg::t_motor_state     o_rd_data
);

    mrdt_pkg::t_motor_state r_mem [mrdt_pkg::NUM_MOTORS];
    logic [mrdt_pkg::NUM_MOTORS-1:0] r_vld;
    mrdt_pkg::t_motor_state r_rd_data;
    logic r_rd_vld;

    // entries never written read as the reset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

[src/mrdt_step.sv]
`default_nettype none
module mrdt_step (
    input  wire mrdt_pkg::t_motor_state i_cur,
    input  wire logic                   i_func,
    input  wire logic signed [8:0]      i_request,
    input  wire logic [7:0]             i_pause_ticks,
    output mrdt_pkg::t_motor_state      o_next
);

    logic [8:0] neg_req;
    logic [7:0] pc_inc;

    assign neg_req = (~i_request) + 9'd1;
    assign pc_inc  = (i_cur.pause_count != 8'hFF) ? i_cur.pause_count + 8'd1
                                                  : i_cur.pause_count;

    always_comb begin
        o_next = i_cur;
        if (i_func == mrdt_pkg::FUNC_SET) begin
            if (i_request[8]) begin
                // saturate the most negative request
                o_next.wanted_duty = neg_req[8] ? 8'hFF : neg_req[7:0];
                o_next.wanted_dir  = mrdt_pkg::DIR_BACK;
            end else begin
                o_next.wanted_duty = i_request[7:0];
                if (i_request[7:0] != 8'd0) begin
                    o_next.wanted_dir = mrdt_pkg::DIR_FWD;
                end
            end
        end else begin
            case (i_cur.mode)
                mrdt_pkg::MODE_STOPPED: begin
                    if (i_cur.wanted_duty != 8'd0) begin
                        if (i_cur.wanted_dir != mrdt_pkg::DIR_NONE) begin
                            o_next.out_duty = i_cur.wanted_duty;
                            o_next.out_dir  = i_cur.wanted_dir;
                        end
                        o_next.applied_dir = i_cur.wanted_dir;
                        o_next.mode        = mrdt_pkg::MODE_RUNNING;
                    end
                end
                mrdt_pkg::MODE_RUNNING: begin
                    if (i_cur.wanted_duty == 8'd0) begin
                        o_next.out_dir  = mrdt_pkg::DIR_NONE;
                        o_next.out_duty = 8'd0;
                        o_next.mode     = mrdt_pkg::MODE_STOPPED;
                    end else if (i_cur.wanted_dir != i_cur.applied_dir) begin
                        // drop the drive for the reversal pause
                        o_next.out_dir     = mrdt_pkg::DIR_NONE;
                        o_next.out_duty    = 8'd0;
                        o_next.applied_dir = i_cur.wanted_dir;
                        o_next.pause_count = 8'd0;
                        o_next.mode        = mrdt_pkg::MODE_PAUSE;
                    end else if (i_cur.wanted_dir != mrdt_pkg::DIR_NONE) begin
                        o_next.out_duty = i_cur.wanted_duty;
                        o_next.out_dir  = i_cur.wanted_dir;
                    end
                end
                mrdt_pkg::MODE_PAUSE: begin
                    o_next.pause_count = pc_inc;
                    if (pc_inc >= i_pause_ticks) begin
                        if (i_cur.wanted_duty != 8'd0) begin
                            if (i_cur.wanted_dir != mrdt_pkg::DIR_NONE) begin
                                o_next.out_duty = i_cur.wanted_duty;
                                o_next.out_dir  = i_cur.wanted_dir;
                            end
                            o_next.mode = mrdt_pkg::MODE_RUNNING;
                        end else begin
                            o_next.mode = mrdt_pkg::MODE_STOPPED;
                        end
                    end
                end
                default: begin
                    o_next = i_cur;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[src/motor_reversal_dead_time_controller_top.sv]
// A set command is accepted in S_IDLE, which reads the motor state, and written back
// in S_MOD; a tick reads motor 0 on acceptance, then in S_MOD registers one result per
// cycle while the output is taken, writing each motor back and fetching the next. A new
// command is accepted only in S_IDLE, once the previous one is done; a result
// left waiting on the output holds the tick. Reset (synchronous, active low): all
// motors stopped, drive off, pause ticks 10.
`default_nettype none
module motor_reversal_dead_time_controller_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // motor_id[0], drive_request[9:1], zero
    input  wire logic        s_axis_tuser,   // func[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // out_motor[0], drive_dir[2:1],
                                             // drive_duty[10:3], zero
    output logic             m_axis_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    typedef enum logic {
        S_IDLE,
        S_MOD
    } t_state;

    t_state r_state;
    logic r_func;
    logic r_id_ok;
    logic [mrdt_pkg::MOTOR_W-1:0] r_motor;
    logic signed [8:0] r_request;
    logic [7:0] r_pause_ticks;
    logic r_out_valid;
    logic [15:0] r_out_data;
    logic r_out_last;

    logic accept;
    logic out_free;
    logic tick_go;
    mrdt_pkg::t_mem_req mem_req;
    mrdt_pkg::t_motor_state rd_data;
    mrdt_pkg::t_motor_state next_state;

    assign pready        = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;
    assign tick_go       = (r_state == S_MOD) && (r_func == mrdt_pkg::FUNC_TICK) && out_free;

    assign prdata = (paddr[2] == mrdt_pkg::REG_PAUSE_TICKS) ? {24'd0, r_pause_ticks} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pause_ticks <= mrdt_pkg::PAUSE_TICKS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mrdt_pkg::REG_PAUSE_TICKS) begin
            r_pause_ticks <= pwdata[7:0];
        end
    end

    always_comb begin
        mem_req         = '0;
        mem_req.wr_addr = r_motor;
        mem_req.wr_data = next_state;
        if (accept) begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = (s_axis_tuser == mrdt_pkg::FUNC_TICK)
                              ? '0 : mrdt_pkg::MOTOR_W'(s_axis_tdata[0]);
        end
        if (r_state == S_MOD) begin
            if (r_func == mrdt_pkg::FUNC_SET) begin
                mem_req.wr_en = r_id_ok;
            end else if (out_free) begin
                mem_req.wr_en = 1'b1;
                // fetch the next motor while this one is written back
                if (r_motor != mrdt_pkg::LAST_MOTOR) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_motor + 1'b1;
                end
            end
        end
    end

    mrdt_state_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    mrdt_step u_step (
        .i_cur         (rd_data),
        .i_func        (r_func),
        .i_request     (r_request),
        .i_pause_ticks (r_pause_ticks),
        .o_next        (next_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_func      <= mrdt_pkg::FUNC_SET;
            r_id_ok     <= 1'b0;
            r_motor     <= '0;
        end else begin
            if (r_out_valid && m_axis_tready && !tick_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_func    <= s_axis_tuser;
                        r_request <= s_axis_tdata[9:1];
                        r_id_ok   <= int'(s_axis_tdata[0]) < mrdt_pkg::NUM_MOTORS;
                        r_motor   <= (s_axis_tuser == mrdt_pkg::FUNC_TICK)
                                     ? '0 : mrdt_pkg::MOTOR_W'(s_axis_tdata[0]);
                        r_state   <= S_MOD;
                    end
                end
                S_MOD: begin
                    if (r_func == mrdt_pkg::FUNC_SET) begin
                        r_state <= S_IDLE;
                    end else if (tick_go) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= {5'd0, next_state.out_duty, next_state.out_dir,
                                        r_motor[0]};
                        r_out_last  <= (r_motor == mrdt_pkg::LAST_MOTOR);
                        if (r_motor == mrdt_pkg::LAST_MOTOR) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_motor <= r_motor + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule
`default_nettype wire

[dv/mrdt_drive_checker.sv]
module mrdt_drive_checker
    import mrdt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_results_due,
    output int          o_results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [MOTOR_W-1:0] motor;
        t_dir               dir;
        logic [7:0]         duty;
        logic               last;
    } drive_result_t;

    t_mode      mode_q        [NUM_MOTORS];
    t_dir       wanted_dir_q  [NUM_MOTORS];
    t_dir       applied_dir_q [NUM_MOTORS];
    logic [7:0] wanted_duty_q [NUM_MOTORS];
    logic [7:0] pause_cnt_q   [NUM_MOTORS];
    t_dir       dir_out_q     [NUM_MOTORS];
    logic [7:0] duty_out_q    [NUM_MOTORS];
    logic [7:0] pause_ticks_q;

    drive_result_t drive_results_due[$];
    drive_result_t head;
    drive_result_t fresh;
    int            fails;
    int            seen;

    function automatic void drive_off(int m);
        dir_out_q[m]  = DIR_NONE;
        duty_out_q[m] = 8'd0;
    endfunction

    // a motor with no wanted direction keeps whatever it drove before
    function automatic void drive_on(int m);
        if (wanted_dir_q[m] != DIR_NONE) begin
            duty_out_q[m] = wanted_duty_q[m];
            dir_out_q[m]  = (wanted_dir_q[m] == DIR_FWD) ? DIR_FWD : DIR_BACK;
        end
    endfunction

    function automatic void advance_motor(int m);
        case (mode_q[m])
            MODE_STOPPED: begin
                if (wanted_duty_q[m] != 8'd0) begin
                    drive_on(m);
                    applied_dir_q[m] = wanted_dir_q[m];
                    mode_q[m]        = MODE_RUNNING;
                end
            end
            MODE_RUNNING: begin
                if (wanted_duty_q[m] == 8'd0) begin
                    drive_off(m);
                    mode_q[m] = MODE_STOPPED;
                end else if (wanted_dir_q[m] != applied_dir_q[m]) begin
                    drive_off(m);
                    applied_dir_q[m] = wanted_dir_q[m];
                    pause_cnt_q[m]   = 8'd0;
                    mode_q[m]        = MODE_PAUSE;
                end else begin
                    drive_on(m);
                end
            end
            MODE_PAUSE: begin
                if (pause_cnt_q[m] != 8'hFF)
                    pause_cnt_q[m] = pause_cnt_q[m] + 8'd1;
                // a pause length of zero ends on the first tick, like one
                if (pause_cnt_q[m] >= pause_ticks_q) begin
                    if (wanted_duty_q[m] != 8'd0) begin
                        drive_on(m);
                        mode_q[m] = MODE_RUNNING;
                    end else begin
                        mode_q[m] = MODE_STOPPED;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void take_request(logic [MOTOR_W-1:0] id, logic [8:0] req);
        logic [9:0] mag;
        if (int'(id) < NUM_MOTORS) begin
            if (req[8]) begin
                // saturate the most negative request to full duty
                mag = 10'h200 - {1'b0, req};
                wanted_duty_q[id] = (mag > 10'd255) ? 8'd255 : mag[7:0];
                wanted_dir_q[id]  = DIR_BACK;
            end else begin
                wanted_duty_q[id] = req[7:0];
                if (req != 9'd0)
                    wanted_dir_q[id] = DIR_FWD;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pause_ticks_q = PAUSE_TICKS_RESET;
            for (int m = 0; m < NUM_MOTORS; m++) begin
                mode_q[m]        = MODE_STOPPED;
                wanted_dir_q[m]  = DIR_NONE;
                applied_dir_q[m] = DIR_NONE;
                wanted_duty_q[m] = 8'd0;
                pause_cnt_q[m]   = 8'd0;
                dir_out_q[m]     = DIR_NONE;
                duty_out_q[m]    = 8'd0;
            end
            drive_results_due.delete();
        end else begin
            // check results before queueing new ones from the same edge
            if (m_axis_tvalid && m_axis_tready) begin
                seen++;
                if (drive_results_due.size() == 0) begin
                    $error("unexpected result transfer: out_motor %0d drive_dir %0d drive_duty %0d",
                           m_axis_tdata[0], m_axis_tdata[2:1], m_axis_tdata[10:3]);
                    fails++;
                end else begin
                    head = drive_results_due.pop_front();
                    if (m_axis_tdata[MOTOR_W-1:0] !== head.motor) begin
                        $error("out_motor: expected %0d, got %0d", head.motor,
                               m_axis_tdata[MOTOR_W-1:0]);
                        fails++;
                    end
                    if (m_axis_tdata[2:1] !== head.dir) begin
                        $error("drive_dir: expected %0d, got %0d", head.dir,
                               m_axis_tdata[2:1]);
                        fails++;
                    end
                    if (m_axis_tdata[10:3] !== head.duty) begin
                        $error("drive_duty: expected %0d, got %0d", head.duty,
                               m_axis_tdata[10:3]);
                        fails++;
                    end
                    if (m_axis_tlast !== head.last) begin
                        $error("last: expected %0d, got %0d", head.last, m_axis_tlast);
                        fails++;
                    end
                end
            end

            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser == FUNC_TICK) begin
                    for (int m = 0; m < NUM_MOTORS; m++) begin
                        advance_motor(m);
                        fresh.motor = MOTOR_W'(m);
                        fresh.dir   = dir_out_q[m];
                        fresh.duty  = duty_out_q[m];
                        fresh.last  = (m == NUM_MOTORS - 1);
                        drive_results_due.push_back(fresh);
                    end
                end else begin
                    take_request(s_axis_tdata[MOTOR_W-1:0], s_axis_tdata[9:1]);
                end
            end

            if (psel && penable && pready && paddr[2] == REG_PAUSE_TICKS) begin
                if (pwrite) begin
                    pause_ticks_q = pwdata[7:0];
                end else if (prdata[7:0] !== pause_ticks_q) begin
                    $error("reversal_pause_ticks: expected %0d, got %0d", pause_ticks_q,
                           prdata[7:0]);
                    fails++;
                end
            end
        end
        o_fail_count   <= fails;
        o_results_due  <= drive_results_due.size();
        o_results_seen <= seen;
    end

endmodule

[dv/tb_motor_reversal_dead_time_controller_top.sv]
module tb_motor_reversal_dead_time_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrdt_pkg::*;

    localparam int WATCHDOG_CYCLES  = 2000;
    localparam int ITEMS_PER_PHASE  = 96;
    localparam int RANDOM_PHASES    = 12;
    localparam int SETTLE_CYCLES    = 8;
    localparam logic [2:0] PAUSE_TICKS_ADDR = {REG_PAUSE_TICKS, 2'b00};

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int results_due;
    int results_seen;
    int idle_cycles   = 0;
    int rx_wait       = 0;
    bit rx_steady     = 1'b0;
    bit tx_steady     = 1'b0;
    int ticks_sent    = 0;
    int commands_sent = 0;
    int pause_writes  = 0;

    always #5 i_clk = ~i_clk;

    motor_reversal_dead_time_controller_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mrdt_drive_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_results_due  (results_due),
        .o_results_seen (results_seen)
    );

    // result side: after each transfer hold tready low for a drawn number of cycles
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_wait = 0;
            m_axis_tready <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            rx_wait = rx_steady ? 0 : $urandom_range(0, 6);
            m_axis_tready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_axis_tready <= (rx_wait == 0);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("motor_reversal_dead_time_controller_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic func, input logic motor, input logic [8:0] request);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {6'd0, request, motor};
        do @(posedge i_clk); while (!s_axis_tready);
        if (func == FUNC_TICK)
            ticks_sent++;
        else
            commands_sent++;
    endtask

    // drop valid, wait for every outstanding result, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the pause length, then read it back with psel held across both transfers
    task automatic write_pause_ticks(input logic [7:0] ticks);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAUSE_TICKS_ADDR;
        pwdata  <= {24'd0, ticks};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        pause_writes++;
    endtask

    initial begin
        logic [7:0] pause_plan [6];
        logic [7:0] ticks;
        int         kind;
        int         mag;
        logic [8:0] request;

        pause_plan = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd2, 8'd7};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset pause length of ten: start, full scale both ways, reverse, stop
        send_item(FUNC_TICK, 1'b0, 9'd0);
        send_item(FUNC_SET, 1'b0, 9'd255);
        send_item(FUNC_SET, 1'b1, 9'h100);
        send_item(FUNC_TICK, 1'b1, 9'h1FF);
        send_item(FUNC_SET, 1'b0, 9'h1FF);
        send_item(FUNC_SET, 1'b1, 9'd0);
        send_item(FUNC_TICK, 1'b0, 9'd0);
        send_item(FUNC_SET, 1'b1, 9'd5);
        send_item(FUNC_TICK, 1'b0, 9'd0);
        drain();

        // zero pause length: the pause ends on its first tick
        write_pause_ticks(8'd0);
        send_item(FUNC_SET, 1'b0, 9'h180);
        send_item(FUNC_TICK, 1'b0, 9'd0);
        send_item(FUNC_SET, 1'b0, 9'd127);
        send_item(FUNC_TICK, 1'b0, 9'd0);
        send_item(FUNC_SET, 1'b0, 9'd0);
        send_item(FUNC_TICK, 1'b0, 9'd0);
        send_item(FUNC_SET, 1'b1, 9'd0);
        send_item(FUNC_TICK, 1'b0, 9'd0);
        drain();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            ticks = (p < 6) ? pause_plan[p] : 8'($urandom_range(1, 12));
            write_pause_ticks(ticks);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady <= ($urandom_range(0, 3) == 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 99) < 45) begin
                    send_item(FUNC_TICK, 1'($urandom), 9'($urandom));
                end else begin
                    kind = $urandom_range(0, 9);
                    mag  = $urandom_range(1, 255);
                    case (kind)
                        0:       request = 9'd0;
                        1:       request = $urandom_range(0, 1) ? 9'h100 : 9'd255;
                        2:       request = 9'($urandom);
                        3:       request = $urandom_range(0, 1) ? 9'h1FF : 9'd1;
                        default: request = $urandom_range(0, 1) ? 9'(mag) : 9'(-mag);
                    endcase
                    send_item(FUNC_SET, 1'($urandom), request);
                end
            end
            drain();
        end

        $display("Sent %0d drive commands and %0d ticks over %0d pause-length writes;",
                 commands_sent, ticks_sent, pause_writes);
        $display("checked %0d motor results against the prediction.", results_seen);
        if (fail_count == 0 && results_due == 0) begin
            $display("motor_reversal_dead_time_controller_top verification clean");
        end else begin
            $display("motor_reversal_dead_time_controller_top verification failed");
        end
        $finish;
    end

endmodule
